// File: rtl/core/dns_pkg.sv
package dns_pkg;

    // Direction codes of a query word
    localparam logic [2:0] DIR_UP    = 3'd0;
    localparam logic [2:0] DIR_DOWN  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;

    // Operation codes of an input word
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int SCORE_W = 28;
    localparam int GAP_SHIFT = 10;
    localparam logic [SCORE_W-1:0] OVERLAP_PENALTY = 28'd1000000;

    // Slot numbers inside the core are carried at the widest table index
    localparam int SLOT_W = 8;

    typedef struct packed {
        logic               en;
        logic [14:0]        h;
        logic [14:0]        w;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_rect;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CUR,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              clear;
        logic              cap_cur;
        logic              cand_vld;
        logic              cand_skip;
        logic [SLOT_W-1:0] cand_slot;
        logic [2:0]        dir;
    } t_eval_ctl;

    typedef struct packed {
        logic              busy;
        logic              have;
        logic [SLOT_W-1:0] best_slot;
    } t_eval_stat;

endpackage

// File: rtl/core/dns_if.sv
interface dns_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [4:0]         slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        size_w;
    logic [14:0]        size_h;
    logic               enabled;
    logic [2:0]         direction;

    modport source (output valid, op, slot, pos_x, pos_y, size_w, size_h, enabled, direction,
                    input ready);
    modport sink   (input valid, op, slot, pos_x, pos_y, size_w, size_h, enabled, direction,
                    output ready);
endinterface

interface dns_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [4:0] neighbour_slot;

    modport source (output valid, found, neighbour_slot, input ready);
    modport sink   (input valid, found, neighbour_slot, output ready);
endinterface

// File: rtl/core/dns_table.sv
module dns_table #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  dns_pkg::t_rect   i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output dns_pkg::t_rect   o_rdata
);
    import dns_pkg::*;

    t_rect r_mem [DEPTH];
    t_rect r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/dns_eval.sv
module dns_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dns_pkg::t_eval_ctl  i_ctl,
    input  dns_pkg::t_rect      i_rect,
    output dns_pkg::t_eval_stat o_stat
);
    import dns_pkg::*;

    // Axis split of the incoming rectangle: a runs along the direction, b across
    logic               w_vert;
    logic               w_pos;
    logic signed [16:0] w_a, w_a_end, w_a_ctr, w_b, w_b_end, w_b_ctr;
    logic signed [16:0] w_pa, w_pb;
    logic        [14:0] w_sa, w_sb;

    always_comb begin
        w_vert = (i_ctl.dir == DIR_UP) || (i_ctl.dir == DIR_DOWN);
        w_pos  = (i_ctl.dir == DIR_DOWN) || (i_ctl.dir == DIR_RIGHT);
        w_pa   = w_vert ? 17'(i_rect.y) : 17'(i_rect.x);
        w_pb   = w_vert ? 17'(i_rect.x) : 17'(i_rect.y);
        w_sa   = w_vert ? i_rect.h : i_rect.w;
        w_sb   = w_vert ? i_rect.w : i_rect.h;
        w_a     = w_pa;
        w_b     = w_pb;
        w_a_end = w_pa + $signed({2'b00, w_sa});
        w_b_end = w_pb + $signed({2'b00, w_sb});
        w_a_ctr = w_pa + $signed({3'b000, w_sa[14:1]});
        w_b_ctr = w_pb + $signed({3'b000, w_sb[14:1]});
    end

    // Current rectangle
    logic signed [16:0] r_cur_a, r_cur_a_end, r_cur_a_ctr, r_cur_b, r_cur_b_end, r_cur_b_ctr;

    // Stage 1: axis terms of a candidate
    logic               r_s1_vld;
    logic [SLOT_W-1:0]  r_s1_slot;
    logic signed [16:0] r_s1_a, r_s1_a_end, r_s1_a_ctr, r_s1_b, r_s1_b_end, r_s1_b_ctr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_cur) begin
            r_cur_a     <= w_a;
            r_cur_a_end <= w_a_end;
            r_cur_a_ctr <= w_a_ctr;
            r_cur_b     <= w_b;
            r_cur_b_end <= w_b_end;
            r_cur_b_ctr <= w_b_ctr;
        end
        r_s1_slot  <= i_ctl.cand_slot;
        r_s1_a     <= w_a;
        r_s1_a_end <= w_a_end;
        r_s1_a_ctr <= w_a_ctr;
        r_s1_b     <= w_b;
        r_s1_b_end <= w_b_end;
        r_s1_b_ctr <= w_b_ctr;
    end

    // Stage 2: centre offsets, edge gap, cross overlap
    logic signed [17:0] w_d_a, w_d_b, w_gap;
    logic               w_ahead, w_ovl;

    always_comb begin
        w_d_a   = 18'(r_s1_a_ctr) - 18'(r_cur_a_ctr);
        w_d_b   = 18'(r_s1_b_ctr) - 18'(r_cur_b_ctr);
        w_gap   = w_pos ? (18'(r_s1_a) - 18'(r_cur_a_end)) : (18'(r_cur_a) - 18'(r_s1_a_end));
        w_ahead = w_pos ? (w_d_a > 18'sd0) : (w_d_a < 18'sd0);
        w_ovl   = (r_s1_b < r_cur_b_end) && (r_s1_b_end > r_cur_b);
    end

    logic               r_s2_vld, r_s2_ovl;
    logic [SLOT_W-1:0]  r_s2_slot;
    logic signed [17:0] r_s2_d_a, r_s2_d_b, r_s2_gap;

    always_ff @(posedge i_clk) begin
        r_s2_slot <= r_s1_slot;
        r_s2_ovl  <= w_ovl;
        r_s2_d_a  <= w_d_a;
        r_s2_d_b  <= w_d_b;
        r_s2_gap  <= w_gap;
    end

    // Stage 3: magnitudes, cone test, gap clamp
    logic [16:0] w_along, w_cross, w_gapc;
    logic        w_keep;

    always_comb begin
        w_along = r_s2_d_a[17] ? 17'(-r_s2_d_a) : r_s2_d_a[16:0];
        w_cross = r_s2_d_b[17] ? 17'(-r_s2_d_b) : r_s2_d_b[16:0];
        w_gapc  = r_s2_gap[17] ? 17'd0 : r_s2_gap[16:0];
        w_keep  = r_s2_vld && (r_s2_ovl || (w_cross <= w_along));
    end

    logic              r_s3_vld, r_s3_ovl;
    logic [SLOT_W-1:0] r_s3_slot;
    logic [16:0]       r_s3_gapc, r_s3_cross;

    always_ff @(posedge i_clk) begin
        r_s3_slot  <= r_s2_slot;
        r_s3_ovl   <= r_s2_ovl;
        r_s3_gapc  <= w_gapc;
        r_s3_cross <= w_cross;
    end

    // Stage 4: score and keep the first lowest
    logic [SCORE_W-1:0] w_score;
    logic [SCORE_W-1:0] r_best;
    logic [SLOT_W-1:0]  r_best_slot;
    logic               r_have;
    logic               w_take;

    always_comb begin
        w_score = (r_s3_ovl ? '0 : OVERLAP_PENALTY)
                + (SCORE_W'(r_s3_gapc) << GAP_SHIFT)
                + SCORE_W'(r_s3_cross);
        w_take  = r_s3_vld && (!r_have || (w_score < r_best));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_have   <= 1'b0;
        end else begin
            r_s1_vld <= i_ctl.cand_vld && !i_ctl.cand_skip && i_rect.en;
            r_s2_vld <= r_s1_vld && w_ahead;
            r_s3_vld <= w_keep;
            if (i_ctl.clear) begin
                r_have <= 1'b0;
            end else if (w_take) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best      <= w_score;
            r_best_slot <= r_s3_slot;
        end
    end

    assign o_stat.busy      = r_s1_vld || r_s2_vld || r_s3_vld;
    assign o_stat.have      = r_have;
    assign o_stat.best_slot = r_best_slot;
endmodule

// File: rtl/core/directional_neighbour_select.sv
// Load word: accepted while idle, writes one table slot, gives no result.
// Query word: the current rectangle is fetched, the slots are walked from zero up to
// element_count (capped at MAX_ELEMENTS), the scoring pipe drains (sooner when the last
// candidates drop out early), then the result is registered; input ready returns when the
// result is written. Out-of-range or non-arrow queries skip the walk and report no neighbour. A waiting result stalls.
// Synchronous active-low reset clears control and element_count; table stays undefined.
module directional_neighbour_select #(
    parameter int MAX_ELEMENTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dns_in_if.sink      i_in,
    dns_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data
);
    import dns_pkg::*;

    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam logic [8:0] MAX_U = 9'(MAX_ELEMENTS);

    t_state            r_state, n_state;
    logic [5:0]        r_elem_cnt;
    logic [8:0]        r_cnt, n_cnt;     // effective count of the running query
    logic [8:0]        r_idx, n_idx;     // next slot to fetch
    logic [SLOT_W-1:0] r_slot;           // current slot of the query
    logic [2:0]        r_dir;
    logic              r_rd_vld;         // table read data holds a candidate
    logic [SLOT_W-1:0] r_rd_slot;
    logic              r_out_vld, r_out_found;
    logic [4:0]        r_out_slot;

    logic [SLOT_W-1:0] w_slot_ext;
    logic [8:0]        w_cnt;
    logic              w_acc, w_load, w_query, w_q_ok, w_issue, w_out_free;
    logic [IDX_W-1:0]  w_raddr;
    t_rect             w_wdata, w_rdata;
    t_eval_ctl         w_ctl;
    t_eval_stat        w_stat;

    // Hold element_count; writes must come only while idle, which the block itself does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_cnt <= '0;
        end else if (i_cfg_we) begin
            r_elem_cnt <= i_cfg_data;
        end
    end

    assign w_slot_ext = SLOT_W'(i_in.slot);
    assign w_cnt      = ({3'b000, r_elem_cnt} > MAX_U) ? MAX_U : {3'b000, r_elem_cnt};
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_load     = w_acc && (i_in.op == OP_LOAD);
    assign w_query    = w_acc && (i_in.op == OP_QUERY);
    // Drop queries whose current slot is outside the count or that are not arrows
    assign w_q_ok     = ({1'b0, w_slot_ext} < w_cnt) && (i_in.direction <= DIR_RIGHT);
    assign w_out_free = !r_out_vld || o_out.ready;

    // Fetch the current rectangle at accept, then walk the slots from zero
    assign w_raddr = (r_state == ST_IDLE) ? w_slot_ext[IDX_W-1:0] : r_idx[IDX_W-1:0];

    assign w_wdata.en = i_in.enabled;
    assign w_wdata.h  = i_in.size_h;
    assign w_wdata.w  = i_in.size_w;
    assign w_wdata.y  = i_in.pos_y;
    assign w_wdata.x  = i_in.pos_x;

    dns_table #(
        .DEPTH (MAX_ELEMENTS),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load && ({1'b0, w_slot_ext} < MAX_U)),
        .i_waddr (w_slot_ext[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_ctl.clear     = w_query;
    assign w_ctl.cap_cur   = (r_state == ST_CUR);
    assign w_ctl.cand_vld  = r_rd_vld;
    assign w_ctl.cand_skip = (r_rd_slot == r_slot);
    assign w_ctl.cand_slot = r_rd_slot;
    assign w_ctl.dir       = r_dir;

    dns_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_rect  (w_rdata),
        .o_stat  (w_stat)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        w_issue = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_cnt   = w_cnt;
                    n_idx   = '0;
                    n_state = w_q_ok ? ST_CUR : ST_FINISH;
                end
            end
            ST_CUR, ST_SCAN: begin
                // Issue one slot per cycle; the query holds at least one slot
                w_issue = 1'b1;
                n_idx   = r_idx + 9'd1;
                n_state = (n_idx >= r_cnt) ? ST_DRAIN : ST_SCAN;
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !w_stat.busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_idx     <= n_idx;
        r_rd_slot <= r_idx[SLOT_W-1:0];
        if (w_query) begin
            r_slot <= w_slot_ext;
            r_dir  <= i_in.direction;
        end
    end

    // Output register: advance the result when the slot frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == ST_FINISH && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && w_out_free) begin
            r_out_found <= w_stat.have;
            r_out_slot  <= w_stat.have ? w_stat.best_slot[4:0] : 5'd0;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.found          = r_out_found;
    assign o_out.neighbour_slot = r_out_slot;

    // A new result word only follows the finish step
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_FINISH))
        else $error("result word raised outside finish step");

    // A word with no neighbour reports slot zero
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_found) |-> (r_out_slot == 5'd0))
        else $error("not-found word carries a slot");

    // The scoring pipe is empty whenever a new word can be taken
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!w_stat.busy && !r_rd_vld))
        else $error("scoring pipe busy while idle");
endmodule

// File: dv/tb_directional_neighbour_select.sv
`default_nettype none

module tb_directional_neighbour_select;
    timeunit 1ns;
    timeprecision 1ps;

    import dns_pkg::*;

    // Table depth of the block under test and a few timing figures
    localparam int TABLE_DEPTH   = 32;
    localparam int SETTLE_CYCLES = 48;      // wait that outlasts the longest query
    localparam int LONG_HOLD     = 400;     // receiver hold-off used by the pressure test
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_WORDS  = 1300;
    localparam longint RUN_LIMIT = 5_000_000;   // ns, far above the slowest passing run

    // Direction codes beyond the four arrows
    localparam logic [2:0] DIR_OK   = 3'd4;
    localparam logic [2:0] DIR_LAST = 3'd7;

    localparam logic [5:0] COUNT_MAX = 6'h3F;

    // Penalty and weight of the scoring rule
    localparam longint FAR_PENALTY = 1000000;
    localparam longint GAP_WEIGHT  = 1024;

    // Rectangle shapes used by the random layouts
    localparam int SHAPE_GRID    = 0;
    localparam int SHAPE_SCATTER = 1;
    localparam int SHAPE_WIDE    = 2;
    localparam int SHAPE_EDGE    = 3;

    typedef struct {
        logic        op;
        logic [4:0]  slot;
        t_rect       rect;
        logic [2:0]  dir;
    } t_word;

    typedef struct {
        logic        found;
        logic [4:0]  nslot;
    } t_answer;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [5:0] i_cfg_data;

    dns_in_if  in_bus ();
    dns_out_if out_bus ();

    directional_neighbour_select #(
        .MAX_ELEMENTS (TABLE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the block: rectangle table, element count, answers in flight
    t_rect      rect_shadow [TABLE_DEPTH];
    logic [5:0] count_shadow;
    t_answer    pending_answers [$];
    int         mismatches;

    // Sender pacing
    bit gap_mode;
    int burst_left;

    // Long hold-off handshake between the tests and the receiver process
    int hold_requests;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT);
        $display("status: fail");
        $finish;
    end

    //------------------------------------------------------------------
    // Neighbour prediction
    //------------------------------------------------------------------

    // Clamp the element count to the table depth
    function automatic int live_count();
        return (count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_shadow);
    endfunction

    // Work out the neighbour the block must pick for one query word
    function automatic t_answer pick_neighbour(input logic [4:0] cur_slot,
                                               input logic [2:0] dir);
        t_answer ans;
        int      lim;
        bit      have;
        bit      ahead;
        bit      overlap;
        longint  cx, cy, cw, ch, ccx, ccy;
        longint  kx, ky, kw, kh, kcx, kcy;
        longint  gap, along, cross_dist, score, best;
        ans.found = 1'b0;
        ans.nslot = '0;
        have = 1'b0;
        best = 0;
        lim = live_count();
        if (int'(cur_slot) >= lim || dir > DIR_RIGHT)
            return ans;
        cx = longint'($signed(rect_shadow[cur_slot].x));
        cy = longint'($signed(rect_shadow[cur_slot].y));
        cw = longint'(rect_shadow[cur_slot].w);
        ch = longint'(rect_shadow[cur_slot].h);
        ccx = cx + cw / 2;
        ccy = cy + ch / 2;
        for (int i = 0; i < lim; i++) begin
            if (i == int'(cur_slot) || !rect_shadow[i].en)
                continue;
            kx = longint'($signed(rect_shadow[i].x));
            ky = longint'($signed(rect_shadow[i].y));
            kw = longint'(rect_shadow[i].w);
            kh = longint'(rect_shadow[i].h);
            kcx = kx + kw / 2;
            kcy = ky + kh / 2;
            if (dir == DIR_UP || dir == DIR_DOWN) begin
                if (dir == DIR_DOWN) begin
                    ahead = kcy > ccy;
                    gap = ky - (cy + ch);
                end else begin
                    ahead = kcy < ccy;
                    gap = cy - (ky + kh);
                end
                along = (kcy > ccy) ? kcy - ccy : ccy - kcy;
                cross_dist = (kcx > ccx) ? kcx - ccx : ccx - kcx;
                overlap = (kx < cx + cw) && (kx + kw > cx);
            end else begin
                if (dir == DIR_RIGHT) begin
                    ahead = kcx > ccx;
                    gap = kx - (cx + cw);
                end else begin
                    ahead = kcx < ccx;
                    gap = cx - (kx + kw);
                end
                along = (kcx > ccx) ? kcx - ccx : ccx - kcx;
                cross_dist = (kcy > ccy) ? kcy - ccy : ccy - kcy;
                overlap = (ky < cy + ch) && (ky + kh > cy);
            end
            if (!ahead)
                continue;
            // outside the cone and not lined up across the axis: drop it
            if (!overlap && cross_dist > along)
                continue;
            if (gap < 0)
                gap = 0;
            score = (overlap ? 0 : FAR_PENALTY) + gap * GAP_WEIGHT + cross_dist;
            // strict compare keeps the lowest slot on a tie
            if (!have || score < best) begin
                have = 1'b1;
                best = score;
                ans.nslot = i[4:0];
            end
        end
        ans.found = have;
        if (!have)
            ans.nslot = '0;
        return ans;
    endfunction

    //------------------------------------------------------------------
    // Word builders
    //------------------------------------------------------------------

    function automatic t_rect rect_at(input int x, input int y, input int w, input int h,
                                      input bit en);
        t_rect r;
        r.x = x[15:0];
        r.y = y[15:0];
        r.w = w[14:0];
        r.h = h[14:0];
        r.en = en;
        return r;
    endfunction

    function automatic t_rect random_rect(input int shape);
        int x, y, w, h;
        case (shape)
            SHAPE_GRID: begin
                // tight grid: plenty of overlap across the axis and equal scores
                x = $urandom_range(0, 5) * 40 + $urandom_range(0, 8) - 4;
                y = $urandom_range(0, 5) * 40 + $urandom_range(0, 8) - 4;
                w = $urandom_range(10, 40);
                h = $urandom_range(10, 40);
            end
            SHAPE_SCATTER: begin
                x = $urandom_range(0, 2000) - 1000;
                y = $urandom_range(0, 2000) - 1000;
                w = $urandom_range(0, 300);
                h = $urandom_range(0, 300);
            end
            SHAPE_WIDE: begin
                x = $urandom;
                y = $urandom;
                w = $urandom;
                h = $urandom;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: x = -32768;
                    1: x = 32767;
                    2: x = 0;
                    default: x = $urandom;
                endcase
                case ($urandom_range(0, 3))
                    0: y = -32768;
                    1: y = 32767;
                    2: y = 0;
                    default: y = $urandom;
                endcase
                w = ($urandom_range(0, 1) != 0) ? 32767 : $urandom_range(0, 1);
                h = ($urandom_range(0, 1) != 0) ? 32767 : $urandom_range(0, 1);
            end
        endcase
        return rect_at(x, y, w, h, $urandom_range(0, 4) != 0);
    endfunction

    function automatic t_word load_word(input int slot, input t_rect r);
        t_word wd;
        wd.op = OP_LOAD;
        wd.slot = slot[4:0];
        wd.rect = r;
        wd.dir = 3'($urandom_range(0, 7));      // ignored on a load
        return wd;
    endfunction

    function automatic t_word query_word(input int slot, input logic [2:0] dir);
        t_word wd;
        wd.op = OP_QUERY;
        wd.slot = slot[4:0];
        wd.rect = rect_at($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1) != 0);
        wd.dir = dir;
        return wd;
    endfunction

    //------------------------------------------------------------------
    // Shared driving tasks
    //------------------------------------------------------------------

    // Offer one word and hold it until the block takes it; update the shadow on accept
    task automatic send_word(input t_word wd);
        int gap;
        if (gap_mode && burst_left == 0) begin
            burst_left = $urandom_range(1, 6);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 4);
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
        in_bus.valid     <= 1'b1;
        in_bus.op        <= wd.op;
        in_bus.slot      <= wd.slot;
        in_bus.pos_x     <= wd.rect.x;
        in_bus.pos_y     <= wd.rect.y;
        in_bus.size_w    <= wd.rect.w;
        in_bus.size_h    <= wd.rect.h;
        in_bus.enabled   <= wd.rect.en;
        in_bus.direction <= wd.dir;
        do @(posedge i_clk); while (!in_bus.ready);
        if (wd.op == OP_LOAD)
            rect_shadow[wd.slot] = wd.rect;
        else
            pending_answers.push_back(pick_neighbour(wd.slot, wd.dir));
    endtask

    // Drop valid, wait for every answer, then let a trailing load settle
    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the element count; call only with the block idle
    task automatic write_count(input logic [5:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        count_shadow = value;
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Zero count: a query must come back empty
    task automatic test_empty_count();
        wait_idle();
        write_count(6'd0);
        send_word(query_word(0, DIR_UP));
    endtask

    // A plus sign around slot 0: each arrow finds its arm, ok and unknown find nothing
    task automatic test_cross_pattern();
        send_word(load_word(0, rect_at(100, 100, 20, 20, 1'b1)));
        send_word(load_word(1, rect_at(100, 40, 20, 20, 1'b1)));
        send_word(load_word(2, rect_at(100, 160, 20, 20, 1'b1)));
        send_word(load_word(3, rect_at(40, 100, 20, 20, 1'b1)));
        send_word(load_word(4, rect_at(160, 100, 20, 20, 1'b1)));
        wait_idle();
        write_count(6'd5);
        send_word(query_word(0, DIR_UP));
        send_word(query_word(0, DIR_DOWN));
        send_word(query_word(0, DIR_LEFT));
        send_word(query_word(0, DIR_RIGHT));
        send_word(query_word(0, DIR_OK));
        send_word(query_word(0, DIR_LAST));
    endtask

    task automatic test_corner_cases();
        // current slot at and past the count
        send_word(query_word(5, DIR_RIGHT));
        send_word(query_word(31, DIR_LEFT));
        // nothing above the top arm
        send_word(query_word(1, DIR_UP));
        // equal scores below: the lower slot wins
        send_word(load_word(4, rect_at(100, 160, 20, 20, 1'b1)));
        send_word(query_word(0, DIR_DOWN));
        // disabled current rectangle still navigates
        send_word(load_word(0, rect_at(100, 100, 20, 20, 1'b0)));
        send_word(query_word(0, DIR_RIGHT));
        // extreme coordinates and sizes
        send_word(load_word(3, rect_at(-32768, -32768, 0, 0, 1'b1)));
        send_word(load_word(4, rect_at(32767, 32767, 32767, 32767, 1'b1)));
        send_word(query_word(0, DIR_LEFT));
        send_word(query_word(0, DIR_DOWN));
        send_word(query_word(4, DIR_UP));
    endtask

    // Hold the result side off for a long stretch while queries keep coming
    task automatic test_backpressure();
        wait_idle();
        gap_mode = 1'b0;
        hold_requests++;
        repeat (8)
            send_word(query_word($urandom_range(0, 4), 3'($urandom_range(0, 3))));
        wait_idle();
        gap_mode = 1'b1;
    endtask

    // Random layouts followed by bursts of queries, with count changes between phases
    task automatic test_random_traffic();
        int       sent;
        int       shape;
        int       n;
        int       lim;
        logic [5:0] next_count;
        sent = 0;
        // fill the whole table before any count above the loaded slots
        shape = $urandom_range(SHAPE_GRID, SHAPE_EDGE);
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            send_word(load_word(s, random_rect(shape)));
            sent++;
        end
        while (sent < RANDOM_WORDS) begin
            gap_mode = $urandom_range(0, 2) != 0;
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0: next_count = 6'd0;
                    1: next_count = 6'd1;
                    2: next_count = 6'(TABLE_DEPTH);
                    3: next_count = 6'(TABLE_DEPTH + 1);
                    4: next_count = COUNT_MAX;
                    default: next_count = 6'($urandom_range(2, TABLE_DEPTH));
                endcase
                wait_idle();
                write_count(next_count);
            end
            lim = live_count();
            shape = $urandom_range(SHAPE_GRID, SHAPE_EDGE);
            n = $urandom_range(2, 10);
            repeat (n) begin
                send_word(load_word((lim > 0) ? $urandom_range(0, lim - 1)
                                              : $urandom_range(0, TABLE_DEPTH - 1),
                                    random_rect(shape)));
                sent++;
            end
            n = $urandom_range(6, 24);
            repeat (n) begin
                send_word(query_word((lim > 0 && $urandom_range(0, 7) != 0)
                                         ? $urandom_range(0, lim - 1)
                                         : $urandom_range(0, TABLE_DEPTH - 1),
                                     3'(($urandom_range(0, 7) != 0) ? $urandom_range(0, 3)
                                                                    : $urandom_range(4, 7))));
                sent++;
            end
            // some noise: any op, any slot, any field
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(0, 1) != 0)
                        send_word(load_word($urandom_range(0, TABLE_DEPTH - 1),
                                            random_rect(SHAPE_WIDE)));
                    else
                        send_word(query_word($urandom_range(0, TABLE_DEPTH - 1),
                                             3'($urandom_range(0, 7))));
                    sent++;
                end
            end
        end
    endtask

    //------------------------------------------------------------------
    // Result side: stall pattern and checker
    //------------------------------------------------------------------

    initial begin
        int mode;
        int phase_left;
        int hold_left;
        int hold_served;
        int tick;
        mode = 0;
        phase_left = 0;
        hold_left = 0;
        hold_served = 0;
        tick = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode = $urandom_range(0, 3);
                    phase_left = $urandom_range(20, 120);
                end
                phase_left--;
                case (mode)
                    0: out_bus.ready <= 1'b1;
                    1: out_bus.ready <= 1'($urandom_range(0, 1));
                    2: out_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: out_bus.ready <= (tick % 4) != 0;
                endcase
            end
        end
    end

    // Compare every accepted answer against the oldest expectation
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected answer found=%0d neighbour_slot=%0d",
                         $time, out_bus.found, out_bus.neighbour_slot);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                if (out_bus.found !== want.found) begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, want.found, out_bus.found);
                    mismatches++;
                end
                if (out_bus.neighbour_slot !== want.nslot) begin
                    $display("%0t: neighbour_slot expected %0d actual %0d",
                             $time, want.nslot, out_bus.neighbour_slot);
                    mismatches++;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------

    initial begin
        mismatches = 0;
        hold_requests = 0;
        gap_mode = 1'b1;
        burst_left = 0;
        count_shadow = '0;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_data       <= '0;
        in_bus.valid     <= 1'b0;
        in_bus.op        <= OP_LOAD;
        in_bus.slot      <= '0;
        in_bus.pos_x     <= '0;
        in_bus.pos_y     <= '0;
        in_bus.size_w    <= '0;
        in_bus.size_h    <= '0;
        in_bus.enabled   <= 1'b0;
        in_bus.direction <= DIR_UP;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_count();
        test_cross_pattern();
        test_corner_cases();
        test_backpressure();
        test_random_traffic();

        // drain whatever is still in flight
        in_bus.valid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && pending_answers.size() != 0; k++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            $display("%0t: %0d expected answers never arrived", $time, pending_answers.size());
            mismatches += pending_answers.size();
        end
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
